/* rtl/aed_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aed_pkg: shared constants and types
// Register indexes, fixed widths and constants of the envelope detector.
// ---------------------------------------------------------------------------
package aed_pkg;
    localparam int LEVEL_BITS   = 26;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_DETECT_MODE  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ATTACK_COEF  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE_COEF = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_DB_OUTPUT    = 2'd3;

    localparam logic [1:0] MODE_PEAK = 2'd0;
    localparam logic [1:0] MODE_MS   = 2'd1;
    localparam logic [1:0] MODE_RMS  = 2'd2;

    localparam logic [15:0] ATTACK_RESET  = 16'd59048;
    localparam logic [15:0] RELEASE_RESET = 16'd65081;
    localparam logic [14:0] DB_FLOOR_MAG  = 15'd24576;
    localparam logic [18:0] DB_PER_LOG2   = 19'd394566;
endpackage

/* rtl/aed_stream_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aed_stream_if: valid/ready channel
// Carries one item of WIDTH bits between a source and a sink.
// ---------------------------------------------------------------------------
interface aed_stream_if #(
    parameter int WIDTH = 16
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/audio_envelope_detector.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// audio_envelope_detector: peak / MS / RMS envelope with attack and release
// Bit-serial envelope follower with optional square root and dB output.
// ---------------------------------------------------------------------------
// One sample at a time. A sample is taken when the sequencer is idle. Its level
// is registered at the output and held until taken, while the next sample is
// already being worked on. A level that is still waiting when the next one is
// done stalls the sequencer, and with it the input. A sample passes through
// squaring of the magnitude in MS/RMS modes, compare, smoothing multiply,
// update, a square root in RMS mode below 1.0, and in dB mode a search for
// the leading one and, for a nonzero level, bit-serial mantissa squaring,
// before the output register. The next sample is accepted in the cycle after
// the level is registered. All multiplies except the final constant scaling
// to decibels are shift-and-add over one bit per cycle. The signed level is
// Q1.ENV_FRAC_BITS linear, or Q8.8 dB floored at -96 dB.
// ---------------------------------------------------------------------------
module audio_envelope_detector
    import aed_pkg::*;
#(
    parameter int SAMPLE_BITS   = 16,
    parameter int ENV_FRAC_BITS = 24,
    parameter int COEF_BITS     = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    aed_stream_if.sink               i_sample,
    aed_stream_if.source             o_level
);
    localparam int EW  = ENV_FRAC_BITS + 1;          // envelope incl. 1.0
    localparam int SQ  = 2 * SAMPLE_BITS;            // square width
    localparam int PW  = EW + COEF_BITS;             // product width
    localparam int RW  = 2 * ENV_FRAC_BITS + 2;      // sqrt radicand width
    localparam int MW  = 32;                          // log mantissa width
    localparam int CW  = 7;                           // generic counter width

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_SQR  = 9'b000000010,
        S_CMP  = 9'b000000100,
        S_MUL  = 9'b000001000,
        S_UPD  = 9'b000010000,
        S_SQRT = 9'b000100000,
        S_NORM = 9'b001000000,
        S_LOG  = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [1:0]           r_mode;
    logic [COEF_BITS-1:0] r_att, r_rel;
    logic                 r_db;

    // datapath
    logic [EW-1:0]          r_env;
    logic [SAMPLE_BITS-1:0] r_mag;
    logic [SQ-1:0]          r_acc;      // square accumulator
    logic [EW-1:0]          r_x;
    logic [EW-1:0]          r_d;
    logic                   r_attack;
    logic [COEF_BITS-1:0]   r_coef;
    logic [PW-1:0]          r_prod;
    logic [RW-1:0]          r_rad;
    logic [RW-1:0]          r_rem;
    logic [EW-1:0]          r_root;
    logic [EW-1:0]          r_rep;
    logic [6:0]             r_p;        // leading-one position search
    logic [MW-1:0]          r_m;
    logic [2*MW-1:0]        r_sq;       // mantissa square accumulator
    logic [MW-1:0]          r_sqm;
    logic [15:0]            r_frac;
    logic [4:0]             r_step;
    logic [CW-1:0]          r_cnt;
    logic [LEVEL_BITS-1:0]  r_level;
    logic                   r_ovalid;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PEAK;
            r_att  <= COEF_BITS'(ATTACK_RESET);
            r_rel  <= COEF_BITS'(RELEASE_RESET);
            r_db   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DETECT_MODE:  r_mode <= i_cfg_data[1:0];
                REG_ATTACK_COEF:  r_att  <= COEF_BITS'(i_cfg_data);
                REG_RELEASE_COEF: r_rel  <= COEF_BITS'(i_cfg_data);
                REG_DB_OUTPUT:    r_db   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic w_sqmode;
    assign w_sqmode = (r_mode == MODE_MS) || (r_mode == MODE_RMS);

    // combinational helpers
    logic [SAMPLE_BITS-1:0] w_mag;
    logic [EW-1:0]          w_xpeak, w_xsq, w_xc;
    logic [PW-1:0]          w_t;
    logic [EW-1:0]          w_tn;
    logic [EW:0]            w_newenv;
    logic [RW-1:0]          w_trial;
    logic [2*MW-1:0]        w_sqn;
    logic [MW-1:0]          w_mn;

    // magnitude; the most negative sample reads as 2^(SAMPLE_BITS-1) unsigned
    always_comb begin
        w_mag = i_sample.data[SAMPLE_BITS-1] ? (~i_sample.data + 1'b1) : i_sample.data;
    end

    function automatic logic [EW-1:0] move_peak(input logic [SAMPLE_BITS:0] v);
        logic [EW+SAMPLE_BITS:0] t;
        t = (EW+SAMPLE_BITS+1)'(v) << ENV_FRAC_BITS;
        return EW'(t >> (SAMPLE_BITS - 1));
    endfunction

    function automatic logic [EW-1:0] move_sq(input logic [SQ:0] v);
        logic [SQ+EW:0] t;
        t = (SQ+EW+1)'(v) << ENV_FRAC_BITS;
        return EW'(t >> (2 * (SAMPLE_BITS - 1)));
    endfunction

    // magnitude and square widened by one bit
    logic [SAMPLE_BITS:0] w_magx;
    assign w_magx = (SAMPLE_BITS+1)'(r_mag);
    logic [SQ:0] w_sqx;
    assign w_sqx = (SQ+1)'(r_acc);
    assign w_xpeak = move_peak(w_magx);
    assign w_xsq   = move_sq(w_sqx);

    always_comb begin
        w_xc = w_sqmode ? w_xsq : w_xpeak;
        if (w_xc > (EW'(1) << ENV_FRAC_BITS)) w_xc = EW'(1) << ENV_FRAC_BITS;
    end

    assign w_t  = (r_prod + (PW'(1) << (COEF_BITS - 1))) >> COEF_BITS;
    assign w_tn = EW'(w_t);
    always_comb begin
        if (r_attack) w_newenv = (w_t > PW'(r_x)) ? '0 : {1'b0, r_x - w_tn};
        else          w_newenv = {1'b0, r_x} + (EW+1)'(w_tn);
        if (w_newenv > ((EW+1)'(1) << ENV_FRAC_BITS))
            w_newenv = (EW+1)'(1) << ENV_FRAC_BITS;
    end

    // digit-by-digit square root: one result bit per cycle
    assign w_trial = {r_rem[RW-3:0], r_rad[RW-1 -: 2]} - RW'({r_root, 2'b01});

    // mantissa squaring step: shift-and-add one multiplier bit per cycle
    assign w_sqn = r_sqm[0] ? r_sq + ({{MW{1'b0}}, r_m} << (MW - 1)) : r_sq;
    assign w_mn  = MW'(w_sqn[2*MW-1:30]);

    // dB conversion from frac and position
    logic [23:0]  w_negl;
    logic [47:0]  w_dbp;
    logic [47:0]  w_dbr;
    logic [14:0]  w_dbmag;
    logic [6:0]   w_pl;
    always_comb begin
        w_pl   = r_p;
        w_negl = {8'(7'(ENV_FRAC_BITS) - w_pl), 16'd0} - 24'(r_frac);
        w_dbp  = 48'(w_negl) * 48'(DB_PER_LOG2);
        w_dbr  = (w_dbp + 48'(1 << 23)) >> 24;
        w_dbmag = (w_dbr > 48'(DB_FLOOR_MAG)) ? DB_FLOOR_MAG : 15'(w_dbr);
    end

    assign i_sample.ready = (r_state == S_IDLE);
    assign o_level.valid  = r_ovalid;
    assign o_level.data   = r_level;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_env    <= '0;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
        end else begin
            // drop the level once taken, unless a new one is registered now
            if (o_level.valid && o_level.ready && r_state != S_OUT) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_sample.valid && i_sample.ready) begin
                        r_mag   <= w_mag;
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_state <= w_sqmode ? S_SQR : S_CMP;
                    end
                end
                // square the magnitude, one multiplier bit per cycle
                S_SQR: begin
                    if (r_mag[r_cnt[$clog2(SAMPLE_BITS)-1:0]])
                        r_acc <= r_acc + (SQ'(r_mag) << r_cnt[$clog2(SAMPLE_BITS)-1:0]);
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(SAMPLE_BITS - 1)) r_state <= S_CMP;
                end
                S_CMP: begin
                    r_x      <= w_xc;
                    r_attack <= w_xc > r_env;
                    r_d      <= (w_xc > r_env) ? w_xc - r_env : r_env - w_xc;
                    r_coef   <= (w_xc > r_env) ? r_att : r_rel;
                    r_prod   <= '0;
                    r_cnt    <= '0;
                    r_state  <= S_MUL;
                end
                // coefficient times difference, one coefficient bit per cycle
                S_MUL: begin
                    if (r_coef[0]) r_prod <= r_prod + (PW'(r_d) << r_cnt[$clog2(COEF_BITS)-1:0]);
                    r_coef <= r_coef >> 1;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CW'(COEF_BITS - 1)) r_state <= S_UPD;
                end
                S_UPD: begin
                    r_env  <= EW'(w_newenv);
                    r_rep  <= EW'(w_newenv);
                    r_rad  <= RW'(w_newenv) << ENV_FRAC_BITS;
                    r_rem  <= '0;
                    r_root <= '0;
                    r_cnt  <= '0;
                    if (r_mode == MODE_RMS && !w_newenv[ENV_FRAC_BITS])
                        r_state <= S_SQRT;
                    else if (r_db) begin
                        r_p <= 7'(ENV_FRAC_BITS); r_state <= S_NORM;
                    end else r_state <= S_OUT;
                end
                S_SQRT: begin
                    r_rad <= r_rad << 2;
                    if (!w_trial[RW-1]) begin
                        r_rem  <= w_trial;
                        r_root <= {r_root[EW-2:0], 1'b1};
                    end else begin
                        r_rem  <= {r_rem[RW-3:0], r_rad[RW-1 -: 2]};
                        r_root <= {r_root[EW-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(RW / 2 - 1)) begin
                        r_rep <= (!w_trial[RW-1]) ? {r_root[EW-2:0], 1'b1}
                                                 : {r_root[EW-2:0], 1'b0};
                        if (r_db) begin
                            r_p <= 7'(ENV_FRAC_BITS); r_state <= S_NORM;
                        end else r_state <= S_OUT;
                    end
                end
                // find the leading one, one position per cycle
                S_NORM: begin
                    if (r_rep == '0) begin
                        r_state <= S_OUT;
                    end else if (r_rep[r_p[$clog2(EW)-1:0]] || r_p == '0) begin
                        r_m     <= (r_p > 7'd30) ? MW'(r_rep >> (r_p - 7'd30))
                                                : MW'(64'(r_rep) << (7'd30 - r_p));
                        r_frac  <= '0;
                        r_step  <= '0;
                        r_sq    <= '0;
                        r_cnt   <= '0;
                        r_state <= S_LOG;
                        r_sqm   <= (r_p > 7'd30) ? MW'(r_rep >> (r_p - 7'd30))
                                                : MW'(64'(r_rep) << (7'd30 - r_p));
                    end else r_p <= r_p - 1'b1;
                end
                // square the mantissa bit-serially for each fraction bit
                S_LOG: begin
                    if (r_cnt == CW'(MW - 1)) begin
                        r_cnt  <= '0;
                        r_sq   <= '0;
                        r_frac <= {r_frac[14:0], w_mn[31]};
                        r_m    <= w_mn[31] ? (w_mn >> 1) : w_mn;
                        r_sqm  <= w_mn[31] ? (w_mn >> 1) : w_mn;
                        r_step <= r_step + 1'b1;
                        if (r_step == 5'd15) r_state <= S_OUT;
                    end else begin
                        r_sq  <= w_sqn >> 1;
                        r_sqm <= r_sqm >> 1;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                // hold until the output register is free
                S_OUT: begin
                    if (!r_ovalid || (o_level.valid && o_level.ready)) begin
                        if (!r_db)
                            r_level <= LEVEL_BITS'(r_rep);
                        else if (r_rep == '0)
                            r_level <= -LEVEL_BITS'(DB_FLOOR_MAG);
                        else
                            r_level <= (r_p >= 7'(ENV_FRAC_BITS)) ? '0
                                       : -LEVEL_BITS'(w_dbmag);
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // checks
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sample.ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_env_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_env <= (EW'(1) << ENV_FRAC_BITS)) else $error("envelope above one");
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample.valid && i_sample.ready) |=> r_state != S_IDLE)
        else $error("item dropped");
endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: envelope detector self-checking bench
// Feeds audio samples through peak, mean square, RMS and dB settings with
// varied attack and release coefficients. A bit-accurate level predictor
// supplies the expected level of every accepted sample but the directed rows
// that fix it, and each delivered level is compared with the oldest one waiting.
// Sender gaps, receiver stalls, one long receiver hold-off vary handshake timing.
// ---------------------------------------------------------------------------
module tb_top
    import aed_pkg::*;
();

    localparam int        CLK_HALF   = 10;
    localparam int        DRAIN_CYC  = 800;
    localparam int        RAND_ITEMS = 1525;
    localparam int        NUM_PHASES = 8;
    localparam logic [63:0] ONE_Q24  = 64'd1 << 24;

    typedef logic signed [LEVEL_BITS-1:0] t_level;

    typedef struct {
        logic [1:0]          mode;
        logic                db;
        logic [15:0]         atk;
        logic [15:0]         rel;
        logic signed [15:0]  smp;
        bit                  typed;
        t_level              lvl;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    aed_stream_if #(.WIDTH(16))         sample_if ();
    aed_stream_if #(.WIDTH(LEVEL_BITS)) level_if ();

    audio_envelope_detector u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   (sample_if.sink),
        .o_level    (level_if.source)
    );

    // predictor copy of the block's settings and envelope
    logic [1:0]  cur_mode;
    logic [15:0] cur_atk;
    logic [15:0] cur_rel;
    logic        cur_db;
    logic [63:0] env_q24;

    t_level pending_levels[$];
    int     mismatches = 0;
    int     levels_seen = 0;
    int     items_sent = 0;
    int     send_idle_pct = 0;
    int     stall_pct = 0;
    int     hold_cycles = 0;

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    initial begin
        #400_000_000;
        $display("timeout with %0d levels outstanding", pending_levels.size());
        $display("end of test: mismatches");
        $finish;
    end

    // floor square root
    function automatic logic [63:0] sqrt_floor(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // 20*log10 of a Q1.24 value in Q8.8, floored at -96 dB
    function automatic t_level level_to_db(input logic [63:0] v);
        int          msb;
        logic [63:0] mant;
        logic [63:0] neg_log;
        logic [63:0] mag;
        logic [31:0] frac;
        msb = 63;
        frac = 0;
        while (msb > 0 && v[msb] == 1'b0) msb--;
        mant = (msb > 30) ? (v >> (msb - 30)) : (v << (30 - msb));
        for (int i = 0; i < 16; i++) begin
            mant = (mant * mant) >> 30;
            frac = frac << 1;
            if (mant >= (64'd1 << 31)) begin
                mant = mant >> 1;
                frac[0] = 1'b1;
            end
        end
        if (msb >= 24) return '0;
        neg_log = (64'(24 - msb) << 16) - 64'(frac);
        mag = (neg_log * 64'(DB_PER_LOG2) + (64'd1 << 23)) >> 24;
        if (mag > 64'(DB_FLOOR_MAG)) mag = 64'(DB_FLOOR_MAG);
        return -t_level'(mag);
    endfunction

    // advance the envelope by one sample and return the reported level
    function automatic t_level predict_level(input logic signed [15:0] smp);
        logic [63:0] mag;
        logic [63:0] target;
        logic [63:0] step;
        logic [63:0] nxt;
        logic [63:0] shown;
        mag = smp[15] ? (64'd65536 - 64'(smp[15:0])) : 64'(smp[15:0]);
        if (cur_mode == MODE_MS || cur_mode == MODE_RMS) target = (mag * mag) >> 6;
        else target = mag << 9;
        if (target > ONE_Q24) target = ONE_Q24;
        if (target > env_q24) begin
            step = (64'(cur_atk) * (target - env_q24) + 64'd32768) >> 16;
            nxt = (step > target) ? 64'd0 : target - step;
        end else begin
            step = (64'(cur_rel) * (env_q24 - target) + 64'd32768) >> 16;
            nxt = target + step;
        end
        if (nxt > ONE_Q24) nxt = ONE_Q24;
        env_q24 = nxt;
        shown = nxt;
        if (cur_mode == MODE_RMS) shown = (nxt >= ONE_Q24) ? ONE_Q24 : sqrt_floor(nxt << 24);
        if (!cur_db) return t_level'(shown);
        if (shown == 0) return -t_level'(DB_FLOOR_MAG);
        return level_to_db(shown);
    endfunction

    // drive receiver ready: long hold-off first, else random stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            level_if.ready = 1'b0;
        end else if (hold_cycles > 0) begin
            level_if.ready = 1'b0;
            hold_cycles--;
        end else begin
            level_if.ready = ($urandom_range(99) >= stall_pct);
        end
    end

    // compare each delivered level with the oldest pending one
    always @(posedge i_clk) begin
        t_level want;
        if (i_rst_n && level_if.valid && level_if.ready) begin
            levels_seen++;
            if (pending_levels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected level %0d", $signed(level_if.data));
            end else begin
                want = pending_levels.pop_front();
                if (level_if.data !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("level mismatch: expected %0d got %0d",
                                 want, $signed(level_if.data));
                end
            end
        end
    end

    // write one register; callers put random junk in unused upper bits
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] val);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // wait for the block to drain, then load all four registers
    task automatic load_settings(input logic [1:0] mode, input logic db,
                                 input logic [15:0] atk, input logic [15:0] rel);
        sample_if.valid = 1'b0;
        while (pending_levels.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        write_reg(REG_DETECT_MODE, {14'($urandom), mode});
        write_reg(REG_ATTACK_COEF, atk);
        write_reg(REG_RELEASE_COEF, rel);
        write_reg(REG_DB_OUTPUT, {15'($urandom), db});
        cur_mode = mode;
        cur_db = db;
        cur_atk = atk;
        cur_rel = rel;
    endtask

    // offer one sample until taken; record its expected level
    task automatic send_sample(input logic signed [15:0] smp, input bit typed,
                               input t_level typed_lvl);
        t_level want;
        while ($urandom_range(99) < send_idle_pct) begin
            sample_if.valid = 1'b0;
            @(negedge i_clk);
        end
        sample_if.valid = 1'b1;
        sample_if.data = smp;
        @(posedge i_clk);
        while (!sample_if.ready) @(posedge i_clk);
        want = predict_level(smp);
        pending_levels.push_back(typed ? typed_lvl : want);
        items_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] pick_sample(input int style);
        case (style)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 512)) - 256);
            2: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            3: return 16'sd0;
            default: return 16'($signed($urandom_range(0, 8191)) - 4096);
        endcase
    endfunction

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(60000, 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    t_stim_row directed[] = '{
        '{MODE_PEAK, 1'b0, ATTACK_RESET, RELEASE_RESET, 16'sd0,      1, 26'sd0},
        '{MODE_PEAK, 1'b1, ATTACK_RESET, RELEASE_RESET, 16'sd0,      1, -26'sd24576},
        '{MODE_PEAK, 1'b0, ATTACK_RESET, RELEASE_RESET, 16'sh7FFF,   0, '0},
        '{MODE_PEAK, 1'b0, ATTACK_RESET, RELEASE_RESET, 16'sh8000,   0, '0},
        '{MODE_PEAK, 1'b0, ATTACK_RESET, RELEASE_RESET, -16'sd1,     0, '0},
        '{MODE_PEAK, 1'b0, ATTACK_RESET, RELEASE_RESET, 16'sd1,      0, '0},
        '{MODE_MS,   1'b0, ATTACK_RESET, RELEASE_RESET, 16'sh8000,   0, '0},
        '{MODE_MS,   1'b0, ATTACK_RESET, RELEASE_RESET, 16'sh7FFF,   0, '0},
        '{MODE_MS,   1'b0, ATTACK_RESET, RELEASE_RESET, 16'sd100,    0, '0},
        '{MODE_RMS,  1'b0, ATTACK_RESET, RELEASE_RESET, 16'sh8000,   0, '0},
        '{MODE_RMS,  1'b0, ATTACK_RESET, RELEASE_RESET, 16'sd1234,   0, '0},
        '{MODE_RMS,  1'b0, ATTACK_RESET, RELEASE_RESET, 16'sd0,      0, '0},
        '{2'd3,      1'b0, ATTACK_RESET, RELEASE_RESET, 16'sh8000,   0, '0},
        '{2'd3,      1'b0, ATTACK_RESET, RELEASE_RESET, 16'sd5,      0, '0},
        '{MODE_RMS,  1'b1, ATTACK_RESET, RELEASE_RESET, 16'sd16384,  0, '0},
        '{MODE_RMS,  1'b1, ATTACK_RESET, RELEASE_RESET, -16'sd20000, 0, '0},
        '{MODE_PEAK, 1'b1, ATTACK_RESET, RELEASE_RESET, 16'sd1,      0, '0},
        '{MODE_PEAK, 1'b0, 16'd0,        16'd0,         16'sh7FFF,   1, 26'sd16776704},
        '{MODE_PEAK, 1'b0, 16'd0,        16'd0,         16'sh8000,   1, 26'sd16777216},
        '{MODE_PEAK, 1'b0, 16'd0,        16'd0,         16'sd0,      1, 26'sd0},
        '{MODE_PEAK, 1'b1, 16'd0,        16'd0,         16'sh8000,   1, 26'sd0},
        '{MODE_PEAK, 1'b1, 16'd0,        16'd0,         16'sd0,      1, -26'sd24576},
        '{MODE_PEAK, 1'b0, 16'hFFFF,     16'hFFFF,      16'sh8000,   0, '0},
        '{MODE_PEAK, 1'b0, 16'hFFFF,     16'hFFFF,      16'sd0,      0, '0},
        '{MODE_MS,   1'b0, 16'hFFFF,     16'hFFFF,      16'sh7FFF,   0, '0}
    };

    initial begin
        int per_phase;
        int style;
        int burst;
        sample_if.valid = 1'b0;
        sample_if.data = '0;
        level_if.ready = 1'b0;
        cur_mode = MODE_PEAK;
        cur_atk = ATTACK_RESET;
        cur_rel = RELEASE_RESET;
        cur_db = 1'b0;
        env_q24 = 0;

        // hold reset, release on a falling edge
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // walk the directed table, reloading settings only when they change
        foreach (directed[i]) begin
            if (directed[i].mode != cur_mode || directed[i].db != cur_db ||
                directed[i].atk != cur_atk || directed[i].rel != cur_rel)
                load_settings(directed[i].mode, directed[i].db,
                              directed[i].atk, directed[i].rel);
            send_sample(directed[i].smp, directed[i].typed, directed[i].lvl);
        end

        // random phases over idle patterns and settings
        per_phase = RAND_ITEMS / NUM_PHASES;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            load_settings(2'($urandom), ($urandom_range(2) == 0), pick_coef(), pick_coef());
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 50; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 50; end
                default: begin send_idle_pct = 24; stall_pct = 24; end
            endcase
            if (ph == 2) hold_cycles = 400;
            burst = 0;
            style = 0;
            for (int n = 0; n < per_phase; n++) begin
                if (burst == 0) begin
                    style = $urandom_range(5);
                    burst = $urandom_range(1, 30);
                end
                burst--;
                send_sample(pick_sample(style), 0, '0);
            end
        end
        sample_if.valid = 1'b0;

        // drain remaining levels, then let the block settle
        while (pending_levels.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYC) @(negedge i_clk);

        $display("%0d samples sent, %0d levels checked, %0d mismatches", items_sent,
                 levels_seen, mismatches);
        $display("covered peak, MS, RMS and dB output with extreme coefficients and stalls");
        if (mismatches == 0 && pending_levels.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

/* filelist.f */
rtl/aed_pkg.sv
rtl/aed_stream_if.sv
rtl/audio_envelope_detector.sv
bench/tb_top.sv
